// ===== rtl/core/owfa_pkg.sv =====
// Shared types and constants for the overlapping window frame averager.
// Register indexes, field widths, reset values and divider step count.
// No dependencies.
`timescale 1ns / 1ps

package owfa_pkg;

	// epoch seconds
	typedef logic [31:0] sec_t;
	// per-pixel accumulator word
	typedef logic [15:0] acc_t;

	// configuration register indexes
	localparam logic [1:0] CFG_WINDOW_SECONDS = 2'd0;
	localparam logic [1:0] CFG_FIRST_START    = 2'd1;
	localparam logic [1:0] CFG_PIXELS         = 2'd2;

	localparam int WS_W  = 7;
	localparam int PIF_W = 19;
	localparam int POS_W = 18;

	// register reset values
	localparam logic [WS_W-1:0]  WS_RESET  = 7'd30;
	localparam sec_t             FST_RESET = 32'd0;
	localparam logic [PIF_W-1:0] PIF_RESET = 19'd262144;

	// quotient bits plus one saturation probe
	localparam logic [3:0] DIV_LAST_STEP = 4'd8;

endpackage

// ===== rtl/core/overlapping_window_frame_averager.sv =====
// Overlapping window frame averager: top level with accumulator memories,
// sequencer and a shared bit-serial divider.
// Depends on owfa_pkg.
`timescale 1ns / 1ps

// Usage:
//  s_* channel carries one pixel per transfer: tdata holds pixel_value and
//  frame_time, tuser holds final_frame. Pixels arrive in raster order.
//  m_* channel returns up to two results per pixel (window 0 first) for each
//  window that finishes on that pixel; tlast marks the last pixel of a frame.
//  cfg_* channel writes window_seconds, first_start_time, pixels_in_frame;
//  it is always ready and should only be used while the block is idle.
//  Sequencing: an accepted pixel is evaluated for window 0, then window 1;
//  each finishing window adds nine steps of the shared restoring divider
//  (one quotient bit per cycle, the first step detects saturation) and an
//  emit step that hands the result to the output register. s_tready stays
//  low until both windows are done.
//  Reset: both accumulator memories are swept to zero, one address per cycle,
//  over all MAX_PIXELS addresses; s_tready stays low meanwhile.
//  A stalled receiver holds the output register; the sequencer waits in its
//  emit step until the register is free, then moves to window 1 or idle.
module overlapping_window_frame_averager
	import owfa_pkg::*;
#(
	parameter int MAX_PIXELS = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] pixel_value, [39:8] frame_time
	input  logic        s_tuser,   // [0] final_frame
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] window_start, [49:32] pixel_position,
	                               // [57:50] mean_value, [63:58] zero
	output logic        m_tuser,   // [0] window_id
	output logic        m_tlast,   // last_of_image
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_PIXELS - 1);

	// sequencer codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;

	// configuration registers
	logic [WS_W-1:0]  ws_q;
	sec_t             fst_q;
	logic [PIF_W-1:0] pif_q;

	// window state
	sec_t        begin_q  [2];
	sec_t        finish_q [2];
	logic [15:0] frames_q [2];
	logic [CW-1:0] cnt_q;

	// accumulator memories
	acc_t mem_a [MAX_PIXELS];
	acc_t mem_b [MAX_PIXELS];
	acc_t rd_a_q, rd_b_q;

	// current item
	logic [7:0]  pix_q;
	sec_t        now_q;
	logic        fin_q;
	logic        last_q;
	logic        win_q;
	logic [CW-1:0] clr_q;

	// divider
	acc_t        rem_q;
	logic [23:0] dsh_q;
	logic [8:0]  quo_q;
	logic [3:0]  step_q;
	logic        zero_q;
	sec_t        start_q;

	// output register
	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;
	logic        m_tlast_q;

	logic in_xfer, cfg_xfer, out_load;
	logic active, finish;
	acc_t sum_in, sum_new;
	logic [15:0] frames_new;
	logic last_now;
	logic [31:0] n_clamp, pif_ext;
	logic div_ge;
	logic [7:0] mean;
	logic we_a, we_b;
	logic [CW-1:0] wr_addr;
	acc_t wr_data;
	logic [WS_W-1:0] ws_n;
	sec_t fst_n;
	logic [31:0] pos_ext;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// frame size clamp and end-of-frame test
	always_comb begin
		pif_ext = 32'(pif_q);
		if (pif_ext == 32'd0) begin
			n_clamp = 32'd1;
		end else if (pif_ext > 32'(MAX_PIXELS)) begin
			n_clamp = 32'(MAX_PIXELS);
		end else begin
			n_clamp = pif_ext;
		end
		last_now = (32'(cnt_q) >= (n_clamp - 32'd1));
	end

	// window evaluation for the selected window
	always_comb begin
		sum_in     = win_q ? rd_b_q : rd_a_q;
		active     = (now_q > begin_q[win_q]);
		finish     = fin_q || (now_q > finish_q[win_q]);
		sum_new    = active ? (sum_in + 16'(pix_q)) : sum_in;
		frames_new = active ? (frames_q[win_q] + 16'd1) : frames_q[win_q];
	end

	// shared divider step and result format
	assign div_ge = ({8'd0, rem_q} >= dsh_q);
	always_comb begin
		if (zero_q) begin
			mean = 8'd0;
		end else if (quo_q[8]) begin
			mean = 8'hFF;
		end else begin
			mean = quo_q[7:0];
		end
	end

	assign out_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign pos_ext  = 32'(cnt_q);

	// memory write port select
	always_comb begin
		wr_addr = cnt_q;
		wr_data = '0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_addr = clr_q;
				we_a    = 1'b1;
				we_b    = 1'b1;
			end
			ST_EVAL: begin
				wr_data = sum_new;
				we_a    = !finish && !win_q;
				we_b    = !finish && win_q;
			end
			ST_EMIT: begin
				we_a = out_load && !win_q;
				we_b = out_load && win_q;
			end
			default: begin
			end
		endcase
	end

	// accumulator memories, registered read at the frame position
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (we_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_a[cnt_q];
		rd_b_q <= mem_b[cnt_q];
	end

	// next timing register values for a reload
	always_comb begin
		ws_n  = (cfg_index == CFG_WINDOW_SECONDS) ? cfg_data[WS_W-1:0] : ws_q;
		fst_n = (cfg_index == CFG_FIRST_START) ? cfg_data : fst_q;
	end

	// sequencer, window state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			win_q       <= 1'b0;
			ws_q        <= WS_RESET;
			fst_q       <= FST_RESET;
			pif_q       <= PIF_RESET;
			begin_q[0]  <= FST_RESET;
			begin_q[1]  <= FST_RESET + 32'(WS_RESET >> 1);
			finish_q[0] <= FST_RESET + 32'(WS_RESET);
			finish_q[1] <= FST_RESET + 32'(WS_RESET >> 1) + 32'(WS_RESET);
			frames_q[0] <= '0;
			frames_q[1] <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// configuration writes, timing ones reload both windows
			if (cfg_xfer) begin
				unique case (cfg_index) inside
					CFG_WINDOW_SECONDS, CFG_FIRST_START: begin
						ws_q        <= ws_n;
						fst_q       <= fst_n;
						begin_q[0]  <= fst_n;
						begin_q[1]  <= fst_n + 32'(ws_n >> 1);
						finish_q[0] <= fst_n + 32'(ws_n);
						finish_q[1] <= fst_n + 32'(ws_n >> 1) + 32'(ws_n);
					end
					CFG_PIXELS: begin
						pif_q <= cfg_data[PIF_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// output register drains on transfer
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						win_q   <= 1'b0;
						last_q  <= last_now;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (finish) begin
						rem_q   <= sum_new;
						dsh_q   <= {frames_new, 8'd0};
						zero_q  <= (frames_new == 16'd0);
						quo_q   <= '0;
						step_q  <= '0;
						start_q <= begin_q[win_q];
						state_q <= ST_DIV;
					end else begin
						if (last_q && active) begin
							frames_q[win_q] <= frames_new;
						end
						if (win_q) begin
							cnt_q   <= last_q ? '0 : (cnt_q + CW'(1));
							state_q <= ST_IDLE;
						end else begin
							win_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - dsh_q[15:0];
					end
					quo_q  <= {quo_q[7:0], div_ge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 4'd1;
					if (step_q == DIV_LAST_STEP) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, mean, pos_ext[POS_W-1:0], start_q};
						m_tuser_q  <= win_q;
						m_tlast_q  <= last_q;
						// rollover of the finished window
						if (last_q) begin
							begin_q[win_q]  <= finish_q[win_q];
							finish_q[win_q] <= finish_q[win_q] + 32'(ws_q);
							frames_q[win_q] <= '0;
						end
						if (win_q) begin
							cnt_q   <= last_q ? '0 : (cnt_q + CW'(1));
							state_q <= ST_IDLE;
						end else begin
							win_q   <= 1'b1;
							state_q <= ST_EVAL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q <= s_tdata[7:0];
			now_q <= s_tdata[39:8];
			fin_q <= s_tuser;
		end
	end

	// no pixel is taken during the clearing sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("pixel accepted during memory clear");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten");

	// an accepted pixel blocks the input for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input ready right after transfer");

	// the divider runs its full step count before emitting
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q != DIV_LAST_STEP) |=> (state_q == ST_DIV))
		else $error("divider left early");

endmodule

// ===== verif/tb_overlapping_window_frame_averager.sv =====
// Self-checking testbench for overlapping_window_frame_averager: directed window cases,
// an output stall that backs up the pixel input, and random frame streams under idling.
// Depends on owfa_pkg and the averager RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_overlapping_window_frame_averager;
	import owfa_pkg::*;

	localparam int          MAX_PIXELS       = 262144;
	localparam int          SINK_HOLD_CYCLES = 600;
	// covers a pixel with no result or with a result pair still in the sequencer
	localparam int          BLOCK_SETTLE     = 30;
	// run limit covers the clearing sweep (262144 addresses), about 1300 pixels
	// under stalls, and the drains and register writes
	localparam int unsigned CYCLE_LIMIT      = 1_500_000;

	typedef struct packed {
		logic        win_id;
		sec_t        start;
		logic [17:0] pos;
		logic [7:0]  mean;
		logic        last;
	} avg_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [7:0] pixel_value, [39:8] frame_time
	logic        s_tuser;   // [0] final_frame
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [31:0] window_start, [49:32] pixel_position,
	                        // [57:50] mean_value, [63:58] zero
	logic        m_tuser;   // [0] window_id
	logic        m_tlast;   // last_of_image
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	overlapping_window_frame_averager #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// shadow copy of the averager state
	logic [WS_W-1:0]  cur_ws;
	sec_t             cur_start;
	logic [PIF_W-1:0] cur_pif;
	bit [15:0]        shadow_sum [2][MAX_PIXELS];
	sec_t             win_begin [2];
	sec_t             win_finish [2];
	bit [15:0]        win_frames [2];
	int unsigned      pix_cnt;

	avg_result_t pending_means [$];

	int          src_idle_pct  = 8;
	int          sink_idle_pct = 58;
	logic        hold_active;
	event        sink_hold_ev;
	int unsigned n_pixels  = 0;
	int unsigned n_results = 0;
	int unsigned n_cfg     = 0;
	int unsigned n_errors  = 0;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void load_windows();
		win_begin[0]  = cur_start;
		win_begin[1]  = cur_start + (cur_ws >> 1);
		win_finish[0] = win_begin[0] + cur_ws;
		win_finish[1] = win_begin[1] + cur_ws;
	endfunction

	function automatic void predict_window_means(logic [7:0] pix, sec_t now, logic fin);
		int unsigned n;
		int unsigned pos;
		int unsigned frames;
		int unsigned mean;
		logic        last;
		logic        active;
		logic        done;
		logic [15:0] s;
		n = cur_pif;
		if (n < 1) n = 1;
		if (n > MAX_PIXELS) n = MAX_PIXELS;
		last = (pix_cnt >= n - 1);
		pos  = (pix_cnt >= MAX_PIXELS) ? MAX_PIXELS - 1 : pix_cnt;
		for (int w = 0; w < 2; w++) begin
			active = (now > win_begin[w]);
			done   = fin || (now > win_finish[w]);
			s      = shadow_sum[w][pos];
			if (active) s = s + pix;
			if (done) begin
				frames = win_frames[w];
				if (active) frames = (frames + 1) & 32'hFFFF;
				mean = (frames == 0) ? 0 : s / frames;
				if (mean > 255) mean = 255;
				pending_means.push_back('{win_id: w[0], start: win_begin[w], pos: pos[17:0],
					mean: mean[7:0], last: last});
				s = '0;
			end
			shadow_sum[w][pos] = s;
			// window rollover or frame count at the end of a frame
			if (last) begin
				if (done) begin
					win_begin[w]  = win_finish[w];
					win_finish[w] = win_begin[w] + cur_ws;
					win_frames[w] = '0;
				end else if (active) begin
					win_frames[w] = win_frames[w] + 1;
				end
			end
		end
		pix_cnt = last ? 0 : pix_cnt + 1;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= 100)
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		avg_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_means.size() == 0) begin
				n_errors++;
				$error("unexpected result transfer: tdata 0x%0h", m_tdata);
			end else begin
				exp_r = pending_means.pop_front();
				check_field("window_id", exp_r.win_id, m_tuser);
				check_field("window_start", exp_r.start, m_tdata[31:0]);
				check_field("pixel_position", exp_r.pos, m_tdata[49:32]);
				check_field("mean_value", exp_r.mean, m_tdata[57:50]);
				check_field("last_of_image", exp_r.last, m_tlast);
				check_field("tdata_pad", 64'd0, m_tdata[63:58]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random idling plus an optional long hold
	// ------------------------------------------------------------------
	initial begin
		hold_active = 1'b0;
		forever begin
			@(sink_hold_ev);
			hold_active <= 1'b1;
			repeat (SINK_HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_pixel(input logic [7:0] pix, input sec_t now, input logic fin);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now, pix};
		s_tuser  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_window_means(pix, now, fin);
		n_pixels++;
	endtask

	task automatic send_frame(input sec_t now, input logic fin, input int len);
		for (int i = 0; i < len; i++)
			send_pixel($urandom_range(255), now, fin);
	endtask

	// drop valid and wait until every expected mean has been taken
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		wait_results_done();
		repeat (BLOCK_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WINDOW_SECONDS: begin
				cur_ws = val[WS_W-1:0];
				load_windows();
			end
			CFG_FIRST_START: begin
				cur_start = val;
				load_windows();
			end
			CFG_PIXELS: cur_pif = val[PIF_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed_windows();
		// 4 s windows from 100, window 1 from 102, two-pixel frames
		cfg_write(CFG_WINDOW_SECONDS, 32'd4);
		cfg_write(CFG_FIRST_START, 32'd100);
		cfg_write(CFG_PIXELS, 32'd2);
		send_frame(32'd100, 1'b0, 2);  // neither window active
		send_frame(32'd101, 1'b0, 2);  // window 0 only
		send_frame(32'd103, 1'b0, 2);  // both
		send_frame(32'd105, 1'b0, 2);  // window 0 finishes
		send_frame(32'd107, 1'b0, 2);  // window 1 finishes
		send_frame(32'd108, 1'b1, 2);  // final frame closes both

		// sums grow while the frame count does not: time drops inside each frame
		repeat (2) begin
			send_pixel(8'd255, 32'd111, 1'b0);
			send_pixel(8'd0, 32'd0, 1'b0);
		end
		// quotient saturates on pixel 0
		send_pixel(8'd255, 32'd111, 1'b1);
		send_pixel(8'd0, 32'd111, 1'b1);
		// zero frame count gives zero mean
		send_frame(32'd0, 1'b1, 2);

		// longest window, time near wrap
		cfg_write(CFG_WINDOW_SECONDS, 32'd127);
		cfg_write(CFG_FIRST_START, 32'hFFFF_FFF0);
		send_frame(32'hFFFF_FFFF, 1'b0, 2);

		// short windows and frame size zero
		cfg_write(CFG_PIXELS, 32'd0);
		cfg_write(CFG_WINDOW_SECONDS, 32'd1);
		cfg_write(CFG_FIRST_START, 32'd0);
		send_frame(32'd2, 1'b0, 1);
		cfg_write(CFG_WINDOW_SECONDS, 32'd0);
		cfg_write(CFG_FIRST_START, 32'hFFFF_FFFF);
		send_frame(32'hFFFF_FFFF, 1'b1, 1);

		// oversized frame, then shrink below the running pixel index
		cfg_write(CFG_PIXELS, 32'h7FFFF);
		send_frame(32'd5, 1'b1, 2);
		cfg_write(CFG_PIXELS, 32'd262144);
		cfg_write(CFG_PIXELS, 32'd1);
		send_frame(32'd6, 1'b1, 1);
	endtask

	// receiver holds off while final frames keep coming; input must back up
	task automatic test_output_stall();
		cfg_write(CFG_WINDOW_SECONDS, 32'd8);
		cfg_write(CFG_FIRST_START, 32'd1000);
		cfg_write(CFG_PIXELS, 32'd3);
		src_idle_pct = 0;
		-> sink_hold_ev;
		for (int i = 0; i < 15; i++)
			send_frame(32'd1001 + i, 1'b1, 3);
		wait_results_done();
	endtask

	task automatic test_random_frames(input int n_items, input int src_pct, input int sink_pct);
		int          sent;
		int          run_len;
		int          len;
		int          k;
		sec_t        t;
		logic        fin;
		logic        noisy;
		logic [31:0] ws_val;
		logic [31:0] pif_val;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			// mostly short windows and tiny frames so windows roll often
			ws_val  = ($urandom_range(7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 12);
			pif_val = ($urandom_range(9) == 0) ? $urandom_range(0, 32'h7FFFF)
			                                   : $urandom_range(1, 6);
			cfg_write(CFG_WINDOW_SECONDS, ws_val);
			cfg_write(CFG_FIRST_START, $urandom());
			cfg_write(CFG_PIXELS, pif_val);
			t = cur_start + $urandom_range(0, 2) - 1;
			run_len = $urandom_range(60, 140);
			k = 0;
			while (k < run_len && sent < n_items) begin
				len   = (cur_pif >= 1 && cur_pif <= 6) ? cur_pif : $urandom_range(1, 20);
				fin   = ($urandom_range(24) == 0);
				noisy = ($urandom_range(9) == 0);
				if (noisy) begin
					// broken frame: time and final flag change per pixel
					for (int i = 0; i < len; i++)
						send_pixel($urandom_range(255),
							$urandom_range(1) ? $urandom() : t + $urandom_range(0, 4),
							$urandom_range(3) == 0);
				end else begin
					send_frame(t, fin, len);
				end
				sent += len;
				k    += len;
				t    += $urandom_range(0, cur_ws / 2 + 1);
			end
			// sender pauses until every mean is back
			wait_results_done();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WINDOW_SECONDS;
		cfg_data  = '0;
		cur_ws    = WS_RESET;
		cur_start = FST_RESET;
		cur_pif   = PIF_RESET;
		win_frames[0] = '0;
		win_frames[1] = '0;
		pix_cnt   = 0;
		load_windows();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_windows();
		test_output_stall();
		test_random_frames(420, 8, 58);
		test_random_frames(420, 58, 8);
		test_random_frames(400, 0, 0);

		wait_results_done();
		repeat (BLOCK_SETTLE + 10) @(posedge clk);
		if (pending_means.size() != 0) begin
			n_errors++;
			$error("%0d expected means never arrived", pending_means.size());
		end
		$display("Sent %0d pixels, checked %0d window means, made %0d register writes;",
			n_pixels, n_results, n_cfg);
		$display("covered short and long windows, wrap of time, odd frame sizes and stalls.");
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
